// ===== sv/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, angle table and rounding helpers for the Euler to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int DATA_W       = 32;
   localparam int CW           = 34;
   localparam int LANE_LAT     = 5 + CORDIC_STEPS;
   localparam int MERGE_LAT    = 3;
   localparam int PIPE_LAT     = LANE_LAT + MERGE_LAT;

   localparam logic signed [25:0] FULL_TURN = 26'sd23592960;
   localparam logic signed [13:0] INV_TURN  = 14'sd2913;
   localparam logic signed [20:0] HALF_K_HI = 21'sd585635;
   localparam logic signed [20:0] HALF_K_LO = 21'sd332437;
   localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
   localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sd1073741824;

   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CW-1:0] v;
      case (idx)
         5'd0:  v = CW'(843314857);
         5'd1:  v = CW'(497837829);
         5'd2:  v = CW'(263043837);
         5'd3:  v = CW'(133525159);
         5'd4:  v = CW'(67021687);
         5'd5:  v = CW'(33543516);
         5'd6:  v = CW'(16775851);
         5'd7:  v = CW'(8388437);
         5'd8:  v = CW'(4194283);
         5'd9:  v = CW'(2097149);
         default: v = CW'(64'sd1 <<< (30 - idx));
      endcase
      return v;
   endfunction

   function automatic logic signed [DATA_W-1:0] mul_q30(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic signed [63:0] p;
      p = (64'(a) * 64'(b)) + 64'sd536870912;
      return p[61:30];
   endfunction

endpackage

// ===== sv/e2q_lane.sv =====
// ----------------------------------------------------------------------------
// e2q_lane
// One angle lane: wrap to [-180,180], half angle in radians, CORDIC cos/sin.
// ----------------------------------------------------------------------------
module e2q_lane (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [e2q_pkg::DATA_W-1:0]  angle,
   output logic signed [e2q_pkg::DATA_W-1:0]  cos_out,
   output logic signed [e2q_pkg::DATA_W-1:0]  sin_out
);
   import e2q_pkg::*;

   logic signed [31:0] a1_ff;
   logic signed [9:0]  q1_ff, q2_ff;
   logic signed [27:0] r2_ff;
   logic signed [24:0] r3_ff;
   logic signed [45:0] ph_ff, pl_ff;

   logic signed [29:0] q_prod;
   logic signed [35:0] qm;
   logic signed [27:0] r_fix, r_rnd;
   logic signed [9:0]  q_fix;
   logic signed [67:0] z_sum;

   logic signed [CW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] z_ff [CORDIC_STEPS+1];

   always_comb begin
      q_prod = 30'($signed(angle[31:16])) * 30'(INV_TURN);
      qm     = 36'(q1_ff) * 36'(FULL_TURN);
      if (r2_ff < 0) begin
         r_fix = r2_ff + 28'(FULL_TURN);
         q_fix = q2_ff - 10'sd1;
      end else if (r2_ff >= 28'(FULL_TURN)) begin
         r_fix = r2_ff - 28'(FULL_TURN);
         q_fix = q2_ff + 10'sd1;
      end else begin
         r_fix = r2_ff;
         q_fix = q2_ff;
      end
      if ((r_fix <<< 1) > 28'(FULL_TURN) ||
          ((r_fix <<< 1) == 28'(FULL_TURN) && q_fix[0])) begin
         r_rnd = r_fix - 28'(FULL_TURN);
      end else begin
         r_rnd = r_fix;
      end
      z_sum = (68'(ph_ff) <<< 20) + 68'(pl_ff) + 68'sd2147483648;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= angle;
         q1_ff    <= q_prod[29:20];
         q2_ff    <= q1_ff;
         r2_ff    <= 28'(36'(a1_ff) - qm);
         r3_ff    <= r_rnd[24:0];
         ph_ff    <= 46'(r3_ff) * 46'(HALF_K_HI);
         pl_ff    <= 46'(r3_ff) * 46'(HALF_K_LO);
         x_ff[0]  <= CORDIC_GAIN;
         y_ff[0]  <= '0;
         z_ff[0]  <= z_sum[32+CW-1:32];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (adv) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(5'(i));
            end
         end
      end
   end

   assign cos_out = x_ff[CORDIC_STEPS][DATA_W-1:0];
   assign sin_out = y_ff[CORDIC_STEPS][DATA_W-1:0];

endmodule

// ===== sv/e2q_merge.sv =====
// ----------------------------------------------------------------------------
// e2q_merge
// Combine the three lanes' cos/sin into the quaternion, with saturation.
// ----------------------------------------------------------------------------
module e2q_merge (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [e2q_pkg::DATA_W-1:0] cp,
   input  logic signed [e2q_pkg::DATA_W-1:0] sp,
   input  logic signed [e2q_pkg::DATA_W-1:0] cy,
   input  logic signed [e2q_pkg::DATA_W-1:0] sy,
   input  logic signed [e2q_pkg::DATA_W-1:0] cr,
   input  logic signed [e2q_pkg::DATA_W-1:0] sr,
   output logic signed [e2q_pkg::DATA_W-1:0] quat_x,
   output logic signed [e2q_pkg::DATA_W-1:0] quat_y,
   output logic signed [e2q_pkg::DATA_W-1:0] quat_z,
   output logic signed [e2q_pkg::DATA_W-1:0] quat_w
);
   import e2q_pkg::*;

   logic signed [DATA_W-1:0] crsp_ff, srcp_ff, crcp_ff, srsp_ff, cy_ff, sy_ff;
   logic signed [DATA_W-1:0] t_ff [8];
   logic signed [DATA_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [DATA_W:0]   sx, sy_s, sz, sw;

   function automatic logic signed [DATA_W-1:0] sat(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] o;
      if (v > 33'(ONE_Q30)) begin
         o = ONE_Q30;
      end else if (v < -33'(ONE_Q30)) begin
         o = -ONE_Q30;
      end else begin
         o = v[DATA_W-1:0];
      end
      return o;
   endfunction

   always_comb begin
      sx   = 33'(t_ff[0]) - 33'(t_ff[1]);
      sy_s = -33'(t_ff[2]) - 33'(t_ff[3]);
      sz   = 33'(t_ff[4]) - 33'(t_ff[5]);
      sw   = 33'(t_ff[6]) + 33'(t_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         crsp_ff <= mul_q30(cr, sp);
         srcp_ff <= mul_q30(sr, cp);
         crcp_ff <= mul_q30(cr, cp);
         srsp_ff <= mul_q30(sr, sp);
         cy_ff   <= cy;
         sy_ff   <= sy;
         t_ff[0] <= mul_q30(crsp_ff, sy_ff);
         t_ff[1] <= mul_q30(srcp_ff, cy_ff);
         t_ff[2] <= mul_q30(crsp_ff, cy_ff);
         t_ff[3] <= mul_q30(srcp_ff, sy_ff);
         t_ff[4] <= mul_q30(crcp_ff, sy_ff);
         t_ff[5] <= mul_q30(srsp_ff, cy_ff);
         t_ff[6] <= mul_q30(crcp_ff, cy_ff);
         t_ff[7] <= mul_q30(srsp_ff, sy_ff);
         qx_ff   <= sat(sx);
         qy_ff   <= sat(sy_s);
         qz_ff   <= sat(sz);
         qw_ff   <= sat(sw);
      end
   end

   assign quat_x = qx_ff;
   assign quat_y = qy_ff;
   assign quat_z = qz_ff;
   assign quat_w = qw_ff;

endmodule

// ===== sv/euler_to_quaternion.sv =====
// Throughput: one request per cycle; the CORDIC stages and the merge multipliers
// are fully pipelined, and the whole pipeline holds while a response is stalled.
// Reset: synchronous, active high; clears the valid bits of every stage only.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Three angle lanes in parallel feeding a merge stage that forms x, y, z, w.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [e2q_pkg::DATA_W-1:0] req_pitch_deg,
   input  logic signed [e2q_pkg::DATA_W-1:0] req_yaw_deg,
   input  logic signed [e2q_pkg::DATA_W-1:0] req_roll_deg,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [e2q_pkg::DATA_W-1:0] rsp_quat_x,
   output logic signed [e2q_pkg::DATA_W-1:0] rsp_quat_y,
   output logic signed [e2q_pkg::DATA_W-1:0] rsp_quat_z,
   output logic signed [e2q_pkg::DATA_W-1:0] rsp_quat_w
);
   import e2q_pkg::*;

   logic adv;
   logic vld_ff [PIPE_LAT];
   logic signed [DATA_W-1:0] cp, sp, cy, sy, cr, sr;

   assign rsp_valid = vld_ff[PIPE_LAT-1];
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   e2q_lane u_pitch (.clock(clock), .adv(adv), .angle(req_pitch_deg),
                     .cos_out(cp), .sin_out(sp));
   e2q_lane u_yaw   (.clock(clock), .adv(adv), .angle(req_yaw_deg),
                     .cos_out(cy), .sin_out(sy));
   e2q_lane u_roll  (.clock(clock), .adv(adv), .angle(req_roll_deg),
                     .cos_out(cr), .sin_out(sr));

   e2q_merge u_merge (
      .clock (clock),
      .adv   (adv),
      .cp    (cp),
      .sp    (sp),
      .cy    (cy),
      .sy    (sy),
      .cr    (cr),
      .sr    (sr),
      .quat_x(rsp_quat_x),
      .quat_y(rsp_quat_y),
      .quat_z(rsp_quat_z),
      .quat_w(rsp_quat_w)
   );

endmodule

// ===== dv/tb_euler_to_quaternion.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion
// Drives random and corner pitch/yaw/roll requests into the Euler to
// quaternion pipeline, predicts x/y/z/w in fixed point and checks each
// response in order, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
class quat_scoreboard;
   typedef struct {
      logic signed [31:0] x, y, z, w;
   } quat_type;

   quat_type pending[$];
   int    errors;

   static function longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   static function longint atan_entry(int i);
      longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tbl[i];
      return longint'(1) << (30 - i);
   endfunction

   static function longint wrap_deg(longint a);
      longint m, q, r;
      m = 23592960;
      q = a / m;
      r = a - q * m;
      if (r < 0) begin
         r += m;
         q -= 1;
      end
      if (2 * r > m) r -= m;
      else if (2 * r == m && q[0]) r -= m;
      return r;
   endfunction

   static function void half_trig(logic signed [31:0] deg, output longint c,
                                  output longint s);
      longint r, z, x, y, dx, dy;
      int     n;
      r = wrap_deg(longint'(deg));
      z = fshift(r * 64'sd614083138197 + (64'sd1 <<< 31), 32);
      x = 652032874;
      y = 0;
      n = (e2q_pkg::CORDIC_STEPS > 30) ? 30 : e2q_pkg::CORDIC_STEPS;
      for (int i = 0; i < n; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_entry(i);
         end else begin
            x += dx; y -= dy; z += atan_entry(i);
         end
      end
      c = x;
      s = y;
   endfunction

   static function longint prod(longint a, longint b, longint c);
      longint ab;
      ab = fshift(a * b + (64'sd1 <<< 29), 30);
      return fshift(ab * c + (64'sd1 <<< 29), 30);
   endfunction

   static function logic signed [31:0] sat(longint v);
      if (v > 1073741824) v = 1073741824;
      if (v < -1073741824) v = -1073741824;
      return v[31:0];
   endfunction

   function void note_request(logic signed [31:0] p, yw, rl);
      longint cp, sp, cy, sy, cr, sr;
      quat_type q;
      half_trig(p, cp, sp);
      half_trig(yw, cy, sy);
      half_trig(rl, cr, sr);
      q.x = sat(prod(cr, sp, sy) - prod(sr, cp, cy));
      q.y = sat(-prod(cr, sp, cy) - prod(sr, cp, sy));
      q.z = sat(prod(cr, cp, sy) - prod(sr, sp, cy));
      q.w = sat(prod(cr, cp, cy) + prod(sr, sp, sy));
      pending.push_back(q);
   endfunction

   function void check_response(logic signed [31:0] x, y, z, w);
      quat_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response x=%0d y=%0d z=%0d w=%0d", $time, x, y, z, w);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
         $display("%0t: quat_x expected %0d actual %0d", $time, e.x, x);
         errors++;
      end
      if (y !== e.y) begin
         $display("%0t: quat_y expected %0d actual %0d", $time, e.y, y);
         errors++;
      end
      if (z !== e.z) begin
         $display("%0t: quat_z expected %0d actual %0d", $time, e.z, z);
         errors++;
      end
      if (w !== e.w) begin
         $display("%0t: quat_w expected %0d actual %0d", $time, e.w, w);
         errors++;
      end
   endfunction
endclass

module tb_euler_to_quaternion;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_pitch_deg = '0;
   logic signed [31:0] req_yaw_deg = '0;
   logic signed [31:0] req_roll_deg = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   quat_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_off = 0;
   longint cycles = 0;
   localparam longint CYCLE_LIMIT = 400000;

   euler_to_quaternion u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pitch_deg(req_pitch_deg), .req_yaw_deg(req_yaw_deg),
      .req_roll_deg(req_roll_deg),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: check accepted responses, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_request(logic signed [31:0] p, yw, rl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pitch_deg <= p;
      req_yaw_deg   <= yw;
      req_roll_deg  <= rl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(p, yw, rl);
   endtask

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 23592960 * $signed($urandom_range(20)) - 23592960 * 10
                   + 11796480 * $signed($urandom_range(1)) - 1 + $urandom_range(2);
         2: return $signed($urandom_range(200)) - 100;
         default: return $signed($urandom_range(47185920)) - 23592960;
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         send_request(rand_angle(), rand_angle(), rand_angle());
   endtask

   logic signed [31:0] corners[12];

   initial begin
      corners = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 11796480, -11796480,
                  35389440, -35389440, 5898240, 23592960, -23592960};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 12; i++)
         send_request(corners[i], corners[(i + 5) % 12], corners[(i + 9) % 12]);
      for (int i = 0; i < 8; i++)
         send_request(corners[i + 4], 32'(i * 11796480), corners[i]);

      random_phase(200);
      send_idle_pct = 67;
      random_phase(180);
      send_idle_pct = 0;
      recv_stall_pct = 67;
      random_phase(180);
      send_idle_pct = 24;
      recv_stall_pct = 24;
      random_phase(180);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 120;
      random_phase(140);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
